// ===== design/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

    // default sizes
    localparam int C_QUERY_MAX = 64;
    localparam int C_TEXT_MAX  = 256;

    // fixed field widths of the result port
    localparam int C_SCORE_W = 14;
    localparam int C_MCNT_W  = 7;

    // record widths, sized for the whole supported parameter range
    // (query up to 256 bytes, name up to 1024 bytes)
    localparam int C_CNT_W  = 9;
    localparam int C_LEN_W  = 11;
    // 100 * 256 needs 15 bits
    localparam int C_DIVD_W = 15;

    localparam logic [C_SCORE_W-1:0] C_SCORE_MAX = '1;

    // request codes
    localparam logic C_REQ_QUERY = 1'b0;
    localparam logic C_REQ_TEXT  = 1'b1;

    // depth of the queue between front and back
    localparam int C_RQ_DEPTH = 2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [C_SCORE_W-1:0] score;
        logic [C_MCNT_W-1:0]  hits;
        logic                 full_match;
        logic                 too_long;
    } t_result;

    // one finished name handed from front to back
    typedef struct packed {
        logic [C_SCORE_W-1:0] run_score;
        logic [C_CNT_W-1:0]   hit_cnt;
        logic [C_LEN_W-1:0]   length;
        logic                 full;
        logic                 too_long;
    } t_rec;

endpackage

// ===== design/fuzzy_subsequence_scorer.sv =====
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Greedy fuzzy subsequence scoring of streamed names against a stored query.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  item      in         push / full            i_item   (t_item)
//  result    out        empty / pop            o_result (t_result)
//  config    in         i_cfg_we               i_cfg_wdata (exact case compare)
//
//  the matcher takes one item per cycle while full is low; a byte is scored in
//  the cycle it is taken, using a query byte prefetched from the query memory
//  a fully matched name takes the score unit through take, one divide step per
//  quotient bit and output; any other name goes from take straight to output
//  short names back up in the 2-entry record queue; full rises while it is
//  full, which a result left waiting on the output causes once it backs up
//  reset is synchronous; the query memory is not cleared
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer #(
    parameter int QUERY_MAX = fss_pkg::C_QUERY_MAX,
    parameter int TEXT_MAX  = fss_pkg::C_TEXT_MAX
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             push,
    input  fss_pkg::t_item   i_item,
    output logic             full,
    input  logic             pop,
    output fss_pkg::t_result o_result,
    output logic             empty
);
    import fss_pkg::*;

    logic r_case_sens;
    logic accept;
    logic rec_push, rec_pop, rq_full, rq_empty;
    t_rec rec_in, rec_out;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_sens <= 1'b0;
        end else if (i_cfg_we) begin
            r_case_sens <= i_cfg_wdata;
        end
    end

    assign full   = rq_full;
    assign accept = push && !rq_full;

    // matcher
    fss_front #(
        .QUERY_MAX (QUERY_MAX),
        .TEXT_MAX  (TEXT_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_case_sens (r_case_sens),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    // record queue
    fss_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .i_pop   (rec_pop),
        .o_data  (rec_out),
        .o_full  (rq_full),
        .o_empty (rq_empty)
    );

    // score unit
    fss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (!rq_empty),
        .i_rec       (rec_out),
        .o_rec_pop   (rec_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== design/fss_front.sv =====
// ----------------------------------------------------------------------------
// fss_front
// Query store and per-byte greedy matcher; emits one record per closed name.
// ----------------------------------------------------------------------------
module fss_front #(
    parameter int QUERY_MAX = fss_pkg::C_QUERY_MAX,
    parameter int TEXT_MAX  = fss_pkg::C_TEXT_MAX
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  fss_pkg::t_item i_item,
    input  logic           i_case_sens,
    output logic           o_rec_push,
    output fss_pkg::t_rec  o_rec
);
    import fss_pkg::*;

    localparam int QIW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int QCW = $clog2(QUERY_MAX + 1);
    localparam int TCW = $clog2(TEXT_MAX + 1);
    localparam logic [QCW-1:0] QMAX = QCW'(QUERY_MAX);
    localparam logic [TCW-1:0] TMAX = TCW'(TEXT_MAX);

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        if (!cs && (c inside {[8'h41:8'h5A]})) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // query memory and prefetched byte at the match index
    logic [7:0]     r_mem [QUERY_MAX];
    logic [7:0]     r_qbyte;

    logic [QCW-1:0] r_qlen, n_qlen;
    logic           r_qdone, n_qdone;
    logic [QCW-1:0] r_idx, n_idx;
    logic [TCW-1:0] r_tlen, n_tlen;
    logic [C_SCORE_W-1:0] r_score, n_score;
    logic [QCW-1:0] r_bonus, n_bonus;
    logic           r_prev_m, n_prev_m;
    logic [7:0]     r_prev_c, n_prev_c;
    logic           r_long, n_long;

    logic           is_query, is_text;
    logic           wr_en;
    logic [QIW-1:0] wr_addr, rd_addr;
    logic [7:0]     c;
    logic           hit, word_start, camel;
    logic [QCW-1:0] bonus_inc;
    logic [15:0]    add, sum;
    logic [C_SCORE_W-1:0] sat_score;
    logic [QCW-1:0] step_idx;
    logic [TCW-1:0] step_tlen;
    logic           step_long;
    logic [C_SCORE_W-1:0] step_score;

    assign c        = i_item.char_byte;
    assign is_query = i_accept && (i_item.req_type == C_REQ_QUERY);
    assign is_text  = i_accept && (i_item.req_type == C_REQ_TEXT);

    // a query byte after a finished query restarts at entry zero
    assign wr_en   = is_query && (r_qdone || (r_qlen < QMAX));
    assign wr_addr = r_qdone ? '0 : r_qlen[QIW-1:0];

    // match decision and score increment
    assign hit        = (r_idx < r_qlen) && (fold(c, i_case_sens) == fold(r_qbyte, i_case_sens));
    assign word_start = (r_tlen == '0) || (r_prev_c inside {8'h20, 8'h5F, 8'h2D, 8'h2E});
    assign camel      = (r_tlen != '0) && (c inside {[8'h41:8'h5A]})
                        && (r_prev_c inside {[8'h61:8'h7A]});
    assign bonus_inc  = r_prev_m ? r_bonus + 1'b1 : '0;
    assign add        = 16'd10 + (16'(bonus_inc) << 2) + 16'(bonus_inc)
                        + (word_start ? 16'd15 : 16'd0) + (camel ? 16'd10 : 16'd0);
    assign sum        = {2'b00, r_score} + add;
    assign sat_score  = (sum > 16'(C_SCORE_MAX)) ? C_SCORE_MAX : sum[C_SCORE_W-1:0];

    // scan state after this text byte
    assign step_idx   = hit ? r_idx + 1'b1 : r_idx;
    assign step_score = hit ? sat_score : r_score;
    assign step_tlen  = (r_tlen < TMAX) ? r_tlen + 1'b1 : r_tlen;
    assign step_long  = r_long || (r_tlen == TMAX);

    // next state
    always_comb begin
        n_qlen   = r_qlen;
        n_qdone  = r_qdone;
        n_idx    = r_idx;
        n_tlen   = r_tlen;
        n_score  = r_score;
        n_bonus  = r_bonus;
        n_prev_m = r_prev_m;
        n_prev_c = r_prev_c;
        n_long   = r_long;
        if (is_query) begin
            n_idx    = '0;
            n_tlen   = '0;
            n_score  = '0;
            n_bonus  = '0;
            n_prev_m = 1'b0;
            n_prev_c = '0;
            n_long   = 1'b0;
            n_qlen   = (r_qdone ? '0 : r_qlen) + (wr_en ? QCW'(1) : QCW'(0));
            n_qdone  = i_item.last;
        end else if (is_text) begin
            n_qdone = 1'b1;
            if (i_item.last) begin
                n_idx    = '0;
                n_tlen   = '0;
                n_score  = '0;
                n_bonus  = '0;
                n_prev_m = 1'b0;
                n_prev_c = '0;
                n_long   = 1'b0;
            end else begin
                n_idx    = step_idx;
                n_tlen   = step_tlen;
                n_score  = step_score;
                n_bonus  = hit ? bonus_inc : r_bonus;
                n_prev_m = hit;
                n_prev_c = c;
                n_long   = step_long;
            end
        end
    end

    // record for the back end
    assign o_rec_push        = is_text && i_item.last;
    assign o_rec.run_score   = step_score;
    assign o_rec.hit_cnt     = C_CNT_W'(step_idx);
    assign o_rec.length      = C_LEN_W'(step_tlen);
    assign o_rec.full        = (r_qlen != '0) && (step_idx == r_qlen);
    assign o_rec.too_long    = step_long;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen   <= '0;
            r_qdone  <= 1'b0;
            r_idx    <= '0;
            r_tlen   <= '0;
            r_score  <= '0;
            r_bonus  <= '0;
            r_prev_m <= 1'b0;
            r_prev_c <= '0;
            r_long   <= 1'b0;
        end else begin
            r_qlen   <= n_qlen;
            r_qdone  <= n_qdone;
            r_idx    <= n_idx;
            r_tlen   <= n_tlen;
            r_score  <= n_score;
            r_bonus  <= n_bonus;
            r_prev_m <= n_prev_m;
            r_prev_c <= n_prev_c;
            r_long   <= n_long;
        end
    end

    // query memory with write-through on the prefetch read
    assign rd_addr = n_idx[QIW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= c;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_qbyte <= c;
        end else begin
            r_qbyte <= r_mem[rd_addr];
        end
    end

endmodule

// ===== design/fss_rq.sv =====
// ----------------------------------------------------------------------------
// fss_rq
// Short record queue between the matcher and the score unit.
// ----------------------------------------------------------------------------
module fss_rq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fss_pkg::t_rec i_data,
    input  logic          i_pop,
    output fss_pkg::t_rec o_data,
    output logic          o_full,
    output logic          o_empty
);
    import fss_pkg::*;

    localparam int PW = (C_RQ_DEPTH > 1) ? $clog2(C_RQ_DEPTH) : 1;
    localparam int CW = $clog2(C_RQ_DEPTH + 1);
    localparam logic [PW-1:0] PLAST = PW'(C_RQ_DEPTH - 1);
    localparam logic [CW-1:0] CFULL = CW'(C_RQ_DEPTH);

    t_rec          r_q [C_RQ_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CFULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PLAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PLAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/fss_back.sv =====
// ----------------------------------------------------------------------------
// fss_back
// Density term by bit-serial division and final score, into an output slot.
// ----------------------------------------------------------------------------
module fss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    input  fss_pkg::t_rec    i_rec,
    output logic             o_rec_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output fss_pkg::t_result o_result
);
    import fss_pkg::*;

    localparam int CW = $clog2(C_DIVD_W + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [C_SCORE_W-1:0] r_run, n_run;
    logic [C_MCNT_W-1:0]  r_mcnt, n_mcnt;
    logic                 r_full, n_full;
    logic                 r_long, n_long;
    logic [C_LEN_W-1:0]   r_div, n_div;
    logic [C_LEN_W-1:0]   r_rem, n_rem;
    logic [C_DIVD_W-1:0]  r_quo, n_quo;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic [C_LEN_W:0]     trial, diff;
    logic                 ge;
    logic [15:0]          sum;
    logic                 load;

    // one quotient bit per cycle
    assign trial = {r_rem, r_quo[C_DIVD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    assign sum  = {2'b00, r_run} + {1'b0, r_quo};
    assign load = (r_state == S_DONE) && (!r_out_valid || i_pop);

    assign o_rec_pop = (r_state == S_IDLE) && i_rec_valid;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_mcnt      = r_mcnt;
        n_full      = r_full;
        n_long      = r_long;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_rec_valid) begin
                    n_run  = i_rec.run_score;
                    n_mcnt = i_rec.hit_cnt[C_MCNT_W-1:0];
                    n_full = i_rec.full;
                    n_long = i_rec.too_long;
                    n_div  = i_rec.length;
                    n_rem  = '0;
                    n_cnt  = CW'(C_DIVD_W);
                    if (i_rec.full) begin
                        n_quo   = C_DIVD_W'(i_rec.hit_cnt) * C_DIVD_W'(100);
                        n_state = S_DIV;
                    end else begin
                        n_quo   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? diff[C_LEN_W-1:0] : trial[C_LEN_W-1:0];
                n_quo = {r_quo[C_DIVD_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_out.score       = !r_full ? '0 :
                                        (sum > 16'(C_SCORE_MAX)) ? C_SCORE_MAX :
                                        sum[C_SCORE_W-1:0];
                    n_out.hits        = r_mcnt;
                    n_out.full_match  = r_full;
                    n_out.too_long    = r_long;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_run  <= n_run;
        r_mcnt <= n_mcnt;
        r_full <= n_full;
        r_long <= n_long;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_out  <= n_out;
    end

endmodule

// ===== design/fss_chk.sv =====
// ----------------------------------------------------------------------------
// fss_chk
// Port-level checks of the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module fss_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             pop,
    input logic             empty,
    input fss_pkg::t_result o_result
);
    import fss_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while waiting");

    // a partial match always scores zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.full_match) |-> (o_result.score == '0))
        else $error("nonzero score without full match");

    // a full match needs at least one matched byte
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.full_match) |-> (o_result.hits != '0))
        else $error("full match with no matched bytes");

    // every match adds at least ten
    a_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.full_match) |-> (o_result.score >= C_SCORE_W'(10)))
        else $error("full match score too small");

endmodule

bind fuzzy_subsequence_scorer fss_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);

// ===== tb/fuzzy_subsequence_scorer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_test
// Self-checking bench: queries and names stream through the push/full side,
// an in-bench scorer predicts every name result, and results taken through
// empty/pop are compared field by field, under both case modes and with
// random idling, a long receiver stall, over-length names and long queries.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_test;
    import fss_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 382;

    // score weights
    localparam int W_MATCH   = 10;
    localparam int W_RUN     = 5;
    localparam int W_WORD    = 15;
    localparam int W_CAMEL   = 10;
    localparam int W_DENSITY = 100;
    localparam int RUN_CAP   = 1023;

    // character codes
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_LO_A  = "a";
    localparam logic [7:0] CH_LO_Z  = "z";
    localparam logic [7:0] CASE_BIT = CH_LO_A ^ CH_UP_A;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_wdata = 1'b0;
    logic    push        = 1'b0;
    t_item   i_item      = '0;
    logic    full;
    logic    pop         = 1'b0;
    t_result o_result;
    logic    empty;

    fuzzy_subsequence_scorer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .pop         (pop),
        .o_result    (o_result),
        .empty       (empty)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // items waiting to be sent and bookkeeping
    t_item      pending_items[$];
    t_result    expected_scores[$];
    t_result    head_exp;
    int         n_queued    = 0;
    int         n_taken     = 0;
    int         n_checked   = 0;
    int         n_full      = 0;
    int         n_long      = 0;
    int         n_errors    = 0;
    int         send_idle   = 35;
    int         recv_idle   = 55;
    int         hold_token  = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    int         stall_count = 0;
    logic [7:0] gen_query[$];

    // scorer state, mirrors the block
    logic [7:0] query_mem[C_QUERY_MAX];
    int         query_len     = 0;
    bit         query_closed  = 1'b0;
    int         hit_pos       = 0;
    int         name_len      = 0;
    int         acc_score     = 0;
    int         streak        = 0;
    bit         prev_hit      = 1'b0;
    logic [7:0] prev_byte     = '0;
    bit         name_ovf      = 1'b0;
    bit         case_exact    = 1'b0;

    function automatic logic [7:0] casefold(input logic [7:0] c);
        if (!case_exact && c >= CH_UP_A && c <= CH_UP_Z)
            return c | CASE_BIT;
        return c;
    endfunction

    function automatic bit word_break(input logic [7:0] c);
        return c == CH_SPACE || c == CH_UNDER || c == CH_DASH || c == CH_DOT;
    endfunction

    function automatic int clip_score(input int v);
        return (v > int'(C_SCORE_MAX)) ? int'(C_SCORE_MAX) : v;
    endfunction

    task automatic restart_name();
        hit_pos   = 0;
        name_len  = 0;
        acc_score = 0;
        streak    = 0;
        prev_hit  = 1'b0;
        prev_byte = '0;
        name_ovf  = 1'b0;
    endtask

    // advance the scorer by one accepted item
    task automatic score_item(input t_item it);
        int      gain;
        bit      whole;
        t_result r;
        if (it.req_type == C_REQ_QUERY) begin
            restart_name();
            if (query_closed) begin
                query_len    = 0;
                query_closed = 1'b0;
            end
            if (query_len < C_QUERY_MAX) begin
                query_mem[query_len] = it.char_byte;
                query_len++;
            end
            if (it.last)
                query_closed = 1'b1;
        end else begin
            query_closed = 1'b1;
            if (hit_pos < query_len &&
                casefold(it.char_byte) == casefold(query_mem[hit_pos])) begin
                gain = W_MATCH;
                if (prev_hit) begin
                    if (streak < RUN_CAP)
                        streak++;
                    gain += W_RUN * streak;
                end else begin
                    streak = 0;
                end
                if (name_len == 0 || word_break(prev_byte))
                    gain += W_WORD;
                if (name_len > 0 && it.char_byte >= CH_UP_A && it.char_byte <= CH_UP_Z &&
                    prev_byte >= CH_LO_A && prev_byte <= CH_LO_Z)
                    gain += W_CAMEL;
                acc_score = clip_score(acc_score + gain);
                hit_pos++;
                prev_hit = 1'b1;
            end else begin
                prev_hit = 1'b0;
            end
            prev_byte = it.char_byte;
            if (name_len < C_TEXT_MAX)
                name_len++;
            else
                name_ovf = 1'b1;
            if (it.last) begin
                whole         = query_len > 0 && hit_pos == query_len;
                r.score       = whole ?
                                C_SCORE_W'(clip_score(acc_score + W_DENSITY * hit_pos / name_len))
                                : '0;
                r.hits        = hit_pos[C_MCNT_W-1:0];
                r.full_match  = whole;
                r.too_long    = name_ovf;
                expected_scores.push_back(r);
                n_full += int'(whole);
                n_long += int'(name_ovf);
                restart_name();
            end
        end
    endtask

    // sender: offer items from the pending queue, hold while full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                score_item(i_item);
                n_taken++;
            end
            if (!(push && full)) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
                    push   <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // receiver: take results, compare with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_scores.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, o_result);
                end else begin
                    head_exp = expected_scores.pop_front();
                    check_field("score", 16'(head_exp.score), 16'(o_result.score));
                    check_field("hits", 16'(head_exp.hits), 16'(o_result.hits));
                    check_field("full_match", 16'(head_exp.full_match),
                                16'(o_result.full_match));
                    check_field("too_long", 16'(head_exp.too_long), 16'(o_result.too_long));
                    n_checked++;
                end
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("[fuzzy_subsequence_scorer] ERROR");
                $finish;
            end
        end
    end

    task automatic add_item(input logic req, input logic [7:0] c, input logic lst);
        t_item it;
        it.req_type  = req;
        it.char_byte = c;
        it.last      = lst;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic send_query(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            add_item(C_REQ_QUERY, s[i], close && i == s.len() - 1);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            add_item(C_REQ_TEXT, s[i], close && i == s.len() - 1);
    endtask

    // mostly letters and separators, the rest any byte
    function automatic logic [7:0] noise_byte();
        string pool;
        pool = "abmzABMZ _-.";
        if ($urandom_range(1))
            return pool[$urandom_range(pool.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] maybe_flip(input logic [7:0] c);
        bit letter;
        letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        if (letter && $urandom_range(case_exact ? 19 : 3) == 0)
            return c ^ CASE_BIT;
        return c;
    endfunction

    task automatic rand_query(input int len, input bit close);
        logic [7:0] c;
        gen_query.delete();
        for (int i = 0; i < len; i++) begin
            c = noise_byte();
            gen_query.push_back(c);
            add_item(C_REQ_QUERY, c, close && i == len - 1);
        end
    endtask

    // name built around the query, or plain noise, sometimes over-length
    task automatic rand_name(input bit close);
        logic [7:0] nm[$];
        int         kind;
        int         use_len;
        int         skip;
        int         goal;
        bit         tight;
        kind    = $urandom_range(9);
        use_len = (gen_query.size() < C_QUERY_MAX) ? gen_query.size() : C_QUERY_MAX;
        if (kind < 7) begin
            skip  = (kind == 6 && use_len > 0) ? $urandom_range(use_len - 1) : -1;
            tight = ($urandom_range(1) != 0);
            for (int i = 0; i < use_len; i++) begin
                if (!tight)
                    repeat ($urandom_range(2)) nm.push_back(noise_byte());
                if (i != skip)
                    nm.push_back(maybe_flip(gen_query[i]));
            end
            repeat ($urandom_range(3)) nm.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(12, 1)) nm.push_back(noise_byte());
        end
        if ($urandom_range(49) == 0) begin
            goal = C_TEXT_MAX + $urandom_range(30, 1);
            while (nm.size() < goal)
                nm.push_back(noise_byte());
        end
        if (nm.size() == 0)
            nm.push_back(noise_byte());
        foreach (nm[i])
            add_item(C_REQ_TEXT, nm[i], close && i == nm.size() - 1);
    endtask

    // queries and names; an open query or an unclosed name is followed
    // by text or a fresh query respectively
    task automatic random_items(input int count);
        int target;
        int qlen;
        bit closed;
        bit need_query;
        target     = n_queued + count;
        need_query = 1'b0;
        while (n_queued < target) begin
            if (need_query || gen_query.size() == 0 || $urandom_range(99) < 10) begin
                qlen = ($urandom_range(9) == 0) ?
                       $urandom_range(C_QUERY_MAX + 8, C_QUERY_MAX - 4) :
                       $urandom_range(6, 1);
                rand_query(qlen, $urandom_range(7) != 0);
            end
            closed = $urandom_range(19) != 0;
            rand_name(closed);
            need_query = !closed;
        end
    endtask

    task automatic wait_drain();
        while (n_taken != n_queued || expected_scores.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_case_mode(input bit exact);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= exact;
        case_exact   = exact;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input bit exact, input int s_idle, input int r_idle,
                             input bit squeeze);
        set_case_mode(exact);
        send_idle = s_idle;
        recv_idle = r_idle;
        if (squeeze)
            hold_token++;
        random_items(PHASE_ITEMS);
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty query, folding, camel step, byte extremes,
        // aborted name, unfinished query
        send_text("a", 1'b1);
        send_query("aB", 1'b1);
        send_text("x_Ab", 1'b1);
        send_text("zAB", 1'b1);
        add_item(C_REQ_QUERY, 8'hFF, 1'b0);
        add_item(C_REQ_QUERY, 8'h00, 1'b1);
        add_item(C_REQ_TEXT, 8'hFF, 1'b0);
        add_item(C_REQ_TEXT, 8'h00, 1'b1);
        send_text("q", 1'b0);
        send_query(".", 1'b1);
        send_text(".", 1'b1);
        send_query("k", 1'b0);
        send_text("k", 1'b1);
        send_query("ab", 1'b1);
        send_text("aXb", 1'b1);
        wait_drain();

        // random phases across both case modes and idling mixes
        run_phase(1'b1, 35, 55, 1'b0);
        run_phase(1'b0, 55, 35, 1'b0);
        run_phase(1'b1, 0, 0, 1'b1);
        run_phase(1'b0, 0, 0, 1'b0);

        $display("run covered %0d items and %0d names in both case modes", n_taken, n_checked);
        $display("full matches %0d, over-length names %0d, mismatches %0d",
                 n_full, n_long, n_errors);
        if (n_errors == 0)
            $display("[fuzzy_subsequence_scorer] OK");
        else
            $display("[fuzzy_subsequence_scorer] ERROR");
        $finish;
    end

endmodule
